[hw/rtl/bid_pkg.sv]
// Shared types, codes and opcode tables for the bytecode instruction decoder.
// No dependencies; imported by bid_core and bytecode_instruction_decoder.
package bid_pkg;

  localparam int unsigned NUM_OPCODES = 38;
  localparam logic [5:0]  CLOSURE_OPCODE = 6'd33;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] start_offset;
    logic [7:0]  opcode;
    logic [15:0] operand_first;
    logic [7:0]  operand_second;
    logic [1:0]  num_operands;
    logic [2:0]  byte_length;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic emit;
    logic idle;
  } core_status_t;

  // operand bytes that follow the opcode
  function automatic logic [1:0] op_bytes(input logic [5:0] op);
    logic [1:0] n;
    case (op) inside
      6'd0, 6'd19, 6'd20, [6'd22:6'd25]:         n = 2'd2;
      6'd27, [6'd30:6'd32], 6'd34, 6'd36:        n = 2'd1;
      CLOSURE_OPCODE:                            n = 2'd3;
      default:                                   n = 2'd0;
    endcase
    return n;
  endfunction

  // operands that the opcode defines
  function automatic logic [1:0] arg_count(input logic [5:0] op);
    logic [1:0] n;
    case (op) inside
      6'd0, 6'd19, 6'd20, [6'd22:6'd25], 6'd27,
      [6'd30:6'd32], 6'd34, 6'd36:               n = 2'd1;
      CLOSURE_OPCODE:                            n = 2'd2;
      default:                                   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/bid_core.sv]
// Decode state and single-pass decode logic: opcode table lookup, operand
// gathering and result formation. Depends on bid_pkg.
module bid_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            code_byte,
  input  logic                  end_of_stream,
  output bid_pkg::core_status_t core_status,
  output bid_pkg::result_t      result
);
  import bid_pkg::*;

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [1:0]             bytes_pending, bytes_pending_next;
  logic [5:0]             held_opcode, held_opcode_next;
  logic [OFFSET_BITS-1:0] held_start, held_start_next;
  logic [23:0]            operand_shift, operand_shift_next;

  logic        emit;
  logic [1:0]  nb;
  logic [1:0]  hw;
  logic [1:0]  tw;
  logic [31:0] start_wide;
  logic [31:0] held_wide;
  logic [31:0] held_next_wide;

  assign nb             = op_bytes(code_byte[5:0]);
  assign hw             = op_bytes(held_opcode);
  assign tw             = op_bytes(held_opcode_next);
  assign start_wide     = 32'(byte_offset);
  assign held_wide      = 32'(held_start);
  assign held_next_wide = 32'(held_start_next);

  always_comb begin
    byte_offset_next   = byte_offset + OFFSET_BITS'(1);
    bytes_pending_next = bytes_pending;
    held_opcode_next   = held_opcode;
    held_start_next    = held_start;
    operand_shift_next = operand_shift;
    emit               = 1'b0;
    result             = '0;
    if (bytes_pending == 2'd0) begin
      result.start_offset = start_wide[15:0];
      result.opcode       = code_byte;
      result.byte_length  = 3'd1;
      if (code_byte >= 8'(NUM_OPCODES)) begin
        emit          = 1'b1;
        result.status = ST_UNKNOWN;
      end else if (nb == 2'd0) begin
        emit          = 1'b1;
        result.status = ST_OK;
      end else begin
        held_opcode_next   = code_byte[5:0];
        held_start_next    = byte_offset;
        bytes_pending_next = nb;
        operand_shift_next = '0;
      end
    end else begin
      operand_shift_next = {operand_shift[15:0], code_byte};
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        emit                 = 1'b1;
        result.start_offset  = held_wide[15:0];
        result.opcode        = {2'b00, held_opcode};
        result.num_operands  = arg_count(held_opcode);
        result.byte_length   = {1'b0, hw} + 3'd1;
        result.status        = ST_OK;
        if (held_opcode == CLOSURE_OPCODE) begin
          result.operand_first  = operand_shift_next[23:8];
          result.operand_second = operand_shift_next[7:0];
        end else if (hw == 2'd2) begin
          result.operand_first = operand_shift_next[15:0];
        end else begin
          result.operand_first = {8'h00, operand_shift_next[7:0]};
        end
      end
    end
    if (end_of_stream) begin
      if (!emit && bytes_pending_next != 2'd0) begin
        emit                 = 1'b1;
        result               = '0;
        result.start_offset  = held_next_wide[15:0];
        result.opcode        = {2'b00, held_opcode_next};
        result.num_operands  = arg_count(held_opcode_next);
        result.byte_length   = 3'd1 + {1'b0, tw} - {1'b0, bytes_pending_next};
        result.status        = ST_TRUNCATED;
      end
      byte_offset_next   = '0;
      bytes_pending_next = 2'd0;
      operand_shift_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      bytes_pending <= 2'd0;
      held_opcode   <= 6'd0;
      held_start    <= '0;
      operand_shift <= '0;
    end else if (fire) begin
      byte_offset   <= byte_offset_next;
      bytes_pending <= bytes_pending_next;
      held_opcode   <= held_opcode_next;
      held_start    <= held_start_next;
      operand_shift <= operand_shift_next;
    end
  end

  assign core_status.emit = emit;
  assign core_status.idle = (bytes_pending == 2'd0);

endmodule

[hw/rtl/bytecode_instruction_decoder.sv]
// Top level of the bytecode instruction decoder: input word register,
// decode core and result register. Depends on bid_pkg and bid_core.
//
// Usage:
//   The slave channel takes one bytecode byte per word in s_axis_tdata; the
//   word flagged by s_axis_tlast is the last byte of a stream. The master
//   channel carries one word per decoded instruction, emitted on the cycle
//   after its last byte (or the stream's last byte) is decoded.
//   A byte is first held in the input register and decoded from there; its
//   result word then goes into the result register and m_axis_tvalid is set.
//   Throughput: one byte per cycle without stalls; the decode of a byte is one
//   table lookup and a byte shift between the input and result registers.
//   Only bytes that complete an instruction or end a stream produce a word.
//   A stall on m_axis_tready holds the result word; the input register then
//   holds its byte and s_axis_tready drops once that register is full.
//   Reset (rst, synchronous) empties both registers and sets the stream
//   offset to zero, expecting an opcode. An end of stream does the same for
//   the offset and the operand state.
module bytecode_instruction_decoder #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] start_offset, [23:16] opcode,
                                      // [39:24] operand_first,
                                      // [47:40] operand_second,
                                      // [49:48] num_operands,
                                      // [52:50] byte_length, [55:53] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import bid_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_eos;
  logic         fire;
  logic         accept;
  core_status_t core_status;
  result_t      core_result;
  result_t      out_result;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  bid_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .code_byte    (in_byte),
    .end_of_stream(in_eos),
    .core_status  (core_status),
    .result       (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= core_status.emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && core_status.emit) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {3'b000,
                         out_result.byte_length,
                         out_result.num_operands,
                         out_result.operand_second,
                         out_result.operand_first,
                         out_result.opcode,
                         out_result.start_offset};
  assign m_axis_tuser = out_result.status;

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid)
    else $error("input stalled with empty input register");

  a_eos_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && in_eos) |=> core_status.idle)
    else $error("decoder still gathering operands after end of stream");

  a_unknown_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_result.status == ST_UNKNOWN) |->
      (out_result.byte_length == 3'd1 && out_result.num_operands == 2'd0 &&
       out_result.operand_first == 16'd0))
    else $error("unknown opcode result not a single bare byte");

endmodule
